/* hw/rtl/saft_pkg.sv */
// shared types and codes for the sorted address frequency table
`timescale 1ns / 1ps
package saft_pkg;
    typedef enum logic [1:0] {
        OP_COUNT = 2'd0,
        OP_SORT  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_SORTED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        RD_NONE = 4'd0,
        RD_MID  = 4'd1,
        RD_POS  = 4'd2,
        RD_SHL  = 4'd3,
        RD_IDX  = 4'd4,
        RD_I    = 4'd5,
        RD_J    = 4'd6
    } rsel_t;

    typedef enum logic [2:0] {
        WR_NONE  = 3'd0,
        WR_HIT   = 3'd1,
        WR_SHIFT = 3'd2,
        WR_NEW   = 3'd3,
        WR_SWI   = 3'd4,
        WR_SWJ   = 3'd5
    } wsel_t;

    typedef enum logic [3:0] {
        CL_NONE    = 4'd0,
        CL_LOAD    = 4'd1,
        CL_SRCH    = 4'd2,
        CL_SHFT    = 4'd3,
        CL_SORTI   = 4'd4,
        CL_SORTJ   = 4'd5,
        CL_NEXTI   = 4'd6,
        CL_SAVEI   = 4'd7,
        CL_SAVEJ   = 4'd8,
        CL_DONE    = 4'd9
    } cloop_t;

    typedef struct packed {
        rsel_t   rsel;
        wsel_t   wsel;
        cloop_t  loop;
        logic    res_hit;
        logic    res_full;
        logic    res_new;
        logic    res_sorted;
        logic    res_read;
        logic    res_range;
        logic    set_sorted;
        logic    strobe;
    } cmd_t;

    typedef struct packed {
        op_t   op;
        logic  sorted;
        logic  search_done;
        logic  hit;
        logic  full;
        logic  shift_done;
        logic  idx_ok;
        logic  i_done;
        logic  j_done;
        logic  need_swap;
    } sts_t;
endpackage

/* hw/rtl/sorted_address_frequency_table.sv */
// top level of the sorted address frequency table
// channel | signals                                         | handshake
// command | start, operation, ip_address, entry_index      | start & !busy
// result  | strobe, status, was_found, entry_address,       | strobe, one cycle
//         | entry_count, entries_used                        |
// count: binary search of the table, then on insert each entry above the slot is shifted up
// sort: compare and swap passes over one ram port; read: one indexed table lookup
// reset clears the used entry count and sorted flag; table contents need no clear
// results cannot be stalled
`timescale 1ns / 1ps
module sorted_address_frequency_table #(
    parameter int TABLE_DEPTH = 4096,
    parameter int COUNT_BITS  = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [31:0] ip_address,
    input  logic [11:0] entry_index,
    output logic        strobe,
    output logic [1:0]  status,
    output logic        was_found,
    output logic [31:0] entry_address,
    output logic [23:0] entry_count,
    output logic [12:0] entries_used
);
    saft_pkg::cmd_t cmd;
    saft_pkg::sts_t sts;

    saft_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
    );

    saft_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_BITS(COUNT_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .start(start), .operation(operation),
        .ip_address(ip_address), .entry_index(entry_index), .cmd(cmd), .sts(sts),
        .strobe(strobe), .status(status), .was_found(was_found),
        .entry_address(entry_address), .entry_count(entry_count),
        .entries_used(entries_used)
    );
endmodule

/* hw/rtl/saft_ram.sv */
// generic single port ram with registered read
`timescale 1ns / 1ps
module saft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* hw/rtl/saft_datapath.sv */
// table storage, search, shift and sort datapath
`timescale 1ns / 1ps
module saft_datapath #(
    parameter int TABLE_DEPTH = 4096,
    parameter int COUNT_BITS  = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         operation,
    input  logic [31:0]        ip_address,
    input  logic [11:0]        entry_index,
    input  saft_pkg::cmd_t     cmd,
    output saft_pkg::sts_t     sts,
    output logic               strobe,
    output logic [1:0]         status,
    output logic               was_found,
    output logic [31:0]        entry_address,
    output logic [23:0]        entry_count,
    output logic [12:0]        entries_used
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [NW-1:0] used_reg, lo_reg, hi_reg, k_reg, i_reg, j_reg;
    logic          sorted_reg;
    logic [1:0]    op_reg;
    logic [31:0]   key_reg;
    logic [11:0]   idx_reg;
    logic [31:0]   ta_reg, ja_reg;
    logic [COUNT_BITS-1:0] tc_reg, jc_reg;

    logic [NW-1:0] mid;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          we;
    logic [31:0]   wa, ra;
    logic [COUNT_BITS-1:0] wc, rc, inc;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign inc = (rc == CMAX) ? rc : rc + 1'b1;

    always_comb
    begin
        case (cmd.rsel)
            saft_pkg::RD_MID: raddr = mid[AW-1:0];
            saft_pkg::RD_POS: raddr = lo_reg[AW-1:0];
            saft_pkg::RD_SHL: raddr = AW'(k_reg - 1'b1);
            saft_pkg::RD_IDX: raddr = AW'(idx_reg);
            saft_pkg::RD_I:   raddr = i_reg[AW-1:0];
            saft_pkg::RD_J:   raddr = j_reg[AW-1:0];
            default:          raddr = '0;
        endcase
        we = 1'b1;
        wa = ra;
        wc = rc;
        case (cmd.wsel)
            saft_pkg::WR_HIT:   begin waddr = lo_reg[AW-1:0]; wc = inc; end
            saft_pkg::WR_SHIFT: waddr = k_reg[AW-1:0];
            saft_pkg::WR_NEW:
            begin
                waddr = lo_reg[AW-1:0];
                wa = key_reg;
                wc = COUNT_BITS'(1);
            end
            saft_pkg::WR_SWI:
            begin
                waddr = i_reg[AW-1:0];
                wa = ja_reg;
                wc = jc_reg;
            end
            saft_pkg::WR_SWJ:
            begin
                waddr = j_reg[AW-1:0];
                wa = ta_reg;
                wc = tc_reg;
            end
            default: begin we = 1'b0; waddr = raddr; end
        endcase
    end

    saft_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_addr_ram (
        .clk(clk), .we(we), .addr(we ? waddr : raddr), .wdata(wa), .rdata(ra)
    );
    saft_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_count_ram (
        .clk(clk), .we(we), .addr(we ? waddr : raddr), .wdata(wc), .rdata(rc)
    );

    always_comb
    begin
        sts.op          = saft_pkg::op_t'(op_reg);
        sts.sorted      = sorted_reg;
        sts.search_done = (lo_reg >= hi_reg);
        sts.hit         = (lo_reg < used_reg) && (ra == key_reg);
        sts.full        = (used_reg >= NW'(TABLE_DEPTH));
        sts.shift_done  = (k_reg <= lo_reg);
        sts.idx_ok      = (32'(idx_reg) < 32'(used_reg));
        sts.i_done      = (i_reg >= used_reg);
        sts.j_done      = (j_reg >= used_reg);
        sts.need_swap   = (tc_reg < rc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            sorted_reg <= 1'b0;
            strobe     <= 1'b0;
        end
        else
        begin
            strobe <= cmd.strobe;
            if (cmd.set_sorted)
                sorted_reg <= 1'b1;
            if (cmd.wsel == saft_pkg::WR_NEW)
                used_reg <= used_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && cmd.loop == saft_pkg::CL_LOAD)
        begin
            op_reg  <= operation;
            key_reg <= ip_address;
            idx_reg <= entry_index;
        end
        case (cmd.loop)
            saft_pkg::CL_LOAD:
            begin
                lo_reg <= '0;
                hi_reg <= used_reg;
                k_reg  <= used_reg;
                i_reg  <= '0;
            end
            saft_pkg::CL_SRCH:
                if (ra < key_reg) lo_reg <= mid + 1'b1;
                else hi_reg <= mid;
            saft_pkg::CL_SHFT:  k_reg <= k_reg - 1'b1;
            saft_pkg::CL_SAVEI:
            begin
                ta_reg <= ra;
                tc_reg <= rc;
                j_reg  <= i_reg + 1'b1;
            end
            saft_pkg::CL_SAVEJ:
            begin
                ja_reg <= ra;
                jc_reg <= rc;
            end
            saft_pkg::CL_SORTJ:
            begin
                if (cmd.wsel == saft_pkg::WR_SWJ)
                begin
                    ta_reg <= ja_reg;
                    tc_reg <= jc_reg;
                end
                j_reg <= j_reg + 1'b1;
            end
            saft_pkg::CL_NEXTI: i_reg <= i_reg + 1'b1;
            default: ;
        endcase
        if (cmd.strobe)
        begin
            status        <= saft_pkg::ST_OK;
            was_found     <= 1'b0;
            entry_address <= '0;
            entry_count   <= '0;
            if (cmd.res_hit)
            begin
                was_found     <= 1'b1;
                entry_address <= key_reg;
                entry_count   <= 24'(inc);
            end
            if (cmd.res_full)
            begin
                status        <= saft_pkg::ST_FULL;
                entry_address <= key_reg;
            end
            if (cmd.res_new)
            begin
                entry_address <= key_reg;
                entry_count   <= 24'd1;
            end
            if (cmd.res_sorted)
                status <= saft_pkg::ST_SORTED;
            if (cmd.res_read)
            begin
                entry_address <= ra;
                entry_count   <= 24'(rc);
            end
            if (cmd.res_range)
                status <= saft_pkg::ST_RANGE;
            entries_used <= 13'(used_reg + (cmd.res_new ? 1'b1 : 1'b0));
        end
    end
endmodule

/* hw/rtl/saft_ctrl.sv */
// controller state machine for search, insert, sort and read
`timescale 1ns / 1ps
module saft_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  saft_pkg::sts_t sts,
    output saft_pkg::cmd_t cmd
);
    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_DISP  = 15'b000000000000010,
        S_SRCH  = 15'b000000000000100,
        S_SWAIT = 15'b000000000001000,
        S_CHK   = 15'b000000000010000,
        S_SHFT  = 15'b000000000100000,
        S_RDWT  = 15'b000000001000000,
        S_RDOUT = 15'b000000010000000,
        S_SI    = 15'b000000100000000,
        S_SJ    = 15'b000001000000000,
        S_SJCMP = 15'b000010000000000,
        S_DONE  = 15'b000100000000000,
        S_SRD   = 15'b001000000000000,
        S_SWI   = 15'b010000000000000,
        S_SWJ   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.loop = saft_pkg::CL_LOAD;
                if (start) state_next = S_DISP;
            end
            S_DISP:
            begin
                case (sts.op)
                    saft_pkg::OP_COUNT:
                        if (sts.sorted)
                        begin
                            cmd.strobe = 1'b1;
                            cmd.res_sorted = 1'b1;
                            state_next = S_DONE;
                        end
                        else if (sts.search_done) state_next = S_CHK;
                        else
                        begin
                            cmd.rsel = saft_pkg::RD_MID;
                            state_next = S_SRCH;
                        end
                    saft_pkg::OP_SORT:  state_next = S_SI;
                    saft_pkg::OP_READ:
                    begin
                        cmd.rsel = saft_pkg::RD_IDX;
                        state_next = S_RDWT;
                    end
                    default:
                    begin
                        cmd.strobe = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SRCH:
            begin
                cmd.loop = saft_pkg::CL_SRCH;
                state_next = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (sts.search_done)
                begin
                    cmd.rsel = saft_pkg::RD_POS;
                    state_next = S_CHK;
                end
                else
                begin
                    cmd.rsel = saft_pkg::RD_MID;
                    state_next = S_SRCH;
                end
            end
            S_CHK:
            begin
                if (sts.hit)
                begin
                    cmd.wsel = saft_pkg::WR_HIT;
                    cmd.res_hit = 1'b1;
                    cmd.strobe = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.full)
                begin
                    cmd.res_full = 1'b1;
                    cmd.strobe = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.shift_done)
                begin
                    cmd.wsel = saft_pkg::WR_NEW;
                    cmd.res_new = 1'b1;
                    cmd.strobe = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rsel = saft_pkg::RD_SHL;
                    state_next = S_SHFT;
                end
            end
            S_SHFT:
            begin
                cmd.wsel = saft_pkg::WR_SHIFT;
                cmd.loop = saft_pkg::CL_SHFT;
                state_next = S_RDWT;
            end
            S_RDWT:
            begin
                if (sts.op == saft_pkg::OP_READ)
                begin
                    cmd.rsel = saft_pkg::RD_IDX;
                    state_next = S_RDOUT;
                end
                else state_next = S_CHK;
            end
            S_RDOUT:
            begin
                cmd.strobe = 1'b1;
                if (sts.idx_ok) cmd.res_read = 1'b1;
                else cmd.res_range = 1'b1;
                state_next = S_DONE;
            end
            S_SI:
            begin
                if (sts.i_done)
                begin
                    cmd.set_sorted = 1'b1;
                    cmd.strobe = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rsel = saft_pkg::RD_I;
                    state_next = S_SJ;
                end
            end
            S_SJ:
            begin
                cmd.loop = saft_pkg::CL_SAVEI;
                state_next = S_SJCMP;
            end
            S_SJCMP:
            begin
                if (sts.j_done)
                begin
                    cmd.loop = saft_pkg::CL_NEXTI;
                    state_next = S_SI;
                end
                else
                begin
                    cmd.rsel = saft_pkg::RD_J;
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                if (sts.need_swap)
                begin
                    cmd.loop = saft_pkg::CL_SAVEJ;
                    state_next = S_SWI;
                end
                else
                begin
                    cmd.loop = saft_pkg::CL_SORTJ;
                    state_next = S_SJCMP;
                end
            end
            S_SWI:
            begin
                cmd.wsel = saft_pkg::WR_SWI;
                state_next = S_SWJ;
            end
            S_SWJ:
            begin
                cmd.wsel = saft_pkg::WR_SWJ;
                cmd.loop = saft_pkg::CL_SORTJ;
                state_next = S_SJCMP;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.strobe |=> state_reg == S_DONE)
        else $error("strobe not followed by done");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> state_reg == S_DISP)
        else $error("start not dispatched");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
endmodule
